// File: design/dbu_pkg.sv
// Shared constants, types and state codes for the distance and bearing unit.
package dbu_pkg;

    localparam int TABLE_DEPTH  = 257;
    localparam int TABLE_AW     = 9;
    localparam int ANGLE_W      = 7;
    localparam int NEWTON_STEPS = 14;
    localparam int STEP_W       = 6;
    localparam int RAD_W        = 32;
    localparam int DIV_W        = 32;
    localparam int DIV_CNT_W    = 6;
    localparam int COORD_W      = 15;
    localparam int DIFF_W       = 16;
    localparam int DIST_W       = 16;
    localparam int BEAR_W       = 9;

    localparam logic [BEAR_W-1:0] DEG_90  = 9'd90;
    localparam logic [BEAR_W-1:0] DEG_180 = 9'd180;
    localparam logic [BEAR_W-1:0] DEG_270 = 9'd270;
    localparam logic [BEAR_W-1:0] DEG_360 = 9'd360;
    localparam logic [TABLE_AW-1:0] IDX_MAX = 9'd256;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SETUP  = 8'b0000_0010,
        ST_NDIV   = 8'b0000_0100,
        ST_NWAIT  = 8'b0000_1000,
        ST_IDIV   = 8'b0001_0000,
        ST_IWAIT  = 8'b0010_0000,
        ST_READ   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: design/dbu_ram.sv
// Generic single-port RAM with registered read data.
module dbu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: design/dbu_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module dbu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  dbu_pkg::div_req_t  req,
    output dbu_pkg::div_rsp_t  rsp
);

    logic [dbu_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [dbu_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [dbu_pkg::DIV_W-1:0]     den_reg, den_next;
    logic [dbu_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [dbu_pkg::DIV_W:0]       trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[dbu_pkg::DIV_W-1]};
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            den_next = req.divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[dbu_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = dbu_pkg::DIV_W'(trial - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[dbu_pkg::DIV_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dbu_pkg::DIV_CNT_W'(dbu_pkg::DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: design/distance_bearing_unit_top.sv
// Top level of the distance and bearing unit: sequencer, divider and arcsine table.
// A request is taken when start is high and busy is low; busy stays high until the
// result strobe. A table write (mode 1) does not raise busy. A distance request on a
// common axis goes from setup straight to done. Otherwise it passes a setup state, then
// one divide per Newton step (up to 14 steps on one shared divider), then a divide for
// the table index and a table read. The result is shown for one cycle with valid high
// and cannot be held off. The table holds nothing until written.
module distance_bearing_unit_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               mode,
    input  logic signed [dbu_pkg::COORD_W-1:0] observer_x,
    input  logic signed [dbu_pkg::COORD_W-1:0] observer_y,
    input  logic signed [dbu_pkg::COORD_W-1:0] target_x,
    input  logic signed [dbu_pkg::COORD_W-1:0] target_y,
    input  logic [8:0]                         entry_index,
    input  logic [6:0]                         entry_value,
    output logic                               valid,
    output logic [dbu_pkg::DIST_W-1:0]         distance,
    output logic [dbu_pkg::BEAR_W-1:0]         bearing
);

    dbu_pkg::state_t state_reg, state_next;
    logic signed [dbu_pkg::DIFF_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [dbu_pkg::RAD_W-1:0]   n_reg, n_next, prev_reg, prev_next;
    logic [dbu_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [dbu_pkg::DIST_W-1:0]  dist_reg, dist_next;
    logic [dbu_pkg::BEAR_W-1:0]  bear_reg, bear_next;
    logic                        valid_reg, valid_next;
    logic [dbu_pkg::DIFF_W-1:0]  adx, ady;
    logic [dbu_pkg::RAD_W-1:0]   newt, rad_sq;
    logic [dbu_pkg::TABLE_AW-1:0] ram_addr;
    logic                        ram_we;
    logic [dbu_pkg::ANGLE_W-1:0] ram_rdata;
    logic [dbu_pkg::BEAR_W-1:0]  angle;
    dbu_pkg::div_req_t           dreq;
    dbu_pkg::div_rsp_t           drsp;
    logic signed [dbu_pkg::DIFF_W-1:0] in_dx, in_dy;

    assign in_dx = dbu_pkg::DIFF_W'(target_x) - dbu_pkg::DIFF_W'(observer_x);
    assign in_dy = dbu_pkg::DIFF_W'(observer_y) - dbu_pkg::DIFF_W'(target_y);
    assign adx   = dx_reg[dbu_pkg::DIFF_W-1] ? dbu_pkg::DIFF_W'(-dx_reg) : dx_reg;
    assign ady   = dy_reg[dbu_pkg::DIFF_W-1] ? dbu_pkg::DIFF_W'(-dy_reg) : dy_reg;
    assign rad_sq = dbu_pkg::RAD_W'(adx) * dbu_pkg::RAD_W'(adx)
                  + dbu_pkg::RAD_W'(ady) * dbu_pkg::RAD_W'(ady);
    assign newt  = dbu_pkg::RAD_W'(({1'b0, prev_reg} + {1'b0, drsp.quotient} + 33'd1) >> 1);
    assign angle = {2'b00, ram_rdata};

    dbu_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    dbu_ram #(.WIDTH(dbu_pkg::ANGLE_W), .DEPTH(dbu_pkg::TABLE_DEPTH)) u_table (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(entry_value), .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        n_next     = n_reg;
        prev_next  = prev_reg;
        step_next  = step_reg;
        dist_next  = dist_reg;
        bear_next  = bear_reg;
        valid_next = 1'b0;
        dreq.start    = 1'b0;
        dreq.dividend = n_reg;
        dreq.divisor  = prev_reg;
        ram_we     = 1'b0;
        ram_addr   = entry_index;
        case (state_reg)
            dbu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (mode)
                    begin
                        ram_we = (entry_index <= dbu_pkg::IDX_MAX);
                    end
                    else
                    begin
                        dx_next    = in_dx;
                        dy_next    = in_dy;
                        state_next = dbu_pkg::ST_SETUP;
                    end
                end
            end
            dbu_pkg::ST_SETUP:
            begin
                if (dx_reg == '0)
                begin
                    dist_next  = ady;
                    bear_next  = (dy_reg > 0) ? dbu_pkg::DEG_90 : dbu_pkg::DEG_270;
                    state_next = dbu_pkg::ST_DONE;
                end
                else if (dy_reg == '0)
                begin
                    dist_next  = adx;
                    bear_next  = (dx_reg > 0) ? '0 : dbu_pkg::DEG_180;
                    state_next = dbu_pkg::ST_DONE;
                end
                else
                begin
                    n_next     = rad_sq;
                    prev_next  = rad_sq >> 1;
                    step_next  = '0;
                    state_next = dbu_pkg::ST_NDIV;
                end
            end
            dbu_pkg::ST_NDIV:
            begin
                dreq.start = 1'b1;
                state_next = dbu_pkg::ST_NWAIT;
            end
            dbu_pkg::ST_NWAIT:
            begin
                if (drsp.done)
                begin
                    prev_next = newt;
                    step_next = step_reg + 1'b1;
                    if (newt == prev_reg ||
                        step_reg == dbu_pkg::STEP_W'(dbu_pkg::NEWTON_STEPS - 1))
                    begin
                        state_next = dbu_pkg::ST_IDIV;
                    end
                    else
                    begin
                        state_next = dbu_pkg::ST_NDIV;
                    end
                end
            end
            dbu_pkg::ST_IDIV:
            begin
                // The root is at least 1 here, since the radicand is at least 2.
                dist_next     = (prev_reg > 32'hFFFF) ? 16'hFFFF : prev_reg[15:0];
                dreq.start    = 1'b1;
                dreq.dividend = {8'd0, ady, 8'd0};
                dreq.divisor  = prev_reg;
                state_next    = dbu_pkg::ST_IWAIT;
            end
            dbu_pkg::ST_IWAIT:
            begin
                if (drsp.done)
                begin
                    n_next     = (drsp.quotient > 32'd256) ? 32'd256 : drsp.quotient;
                    state_next = dbu_pkg::ST_READ;
                end
            end
            dbu_pkg::ST_READ:
            begin
                // Address is applied in this cycle; data arrives next cycle.
                ram_addr   = n_reg[8:0];
                step_next  = {1'b1, step_reg[dbu_pkg::STEP_W-2:0]};
                state_next = dbu_pkg::ST_DONE;
            end
            dbu_pkg::ST_DONE:
            begin
                if (step_reg[dbu_pkg::STEP_W-1] && dx_reg != '0 && dy_reg != '0)
                begin
                    if (dx_reg > 0 && dy_reg > 0)
                        bear_next = angle;
                    else if (dx_reg > 0)
                        bear_next = (angle == '0) ? '0 : dbu_pkg::BEAR_W'(dbu_pkg::DEG_360 - angle);
                    else if (dy_reg > 0)
                        bear_next = dbu_pkg::BEAR_W'(dbu_pkg::DEG_180 - angle);
                    else
                        bear_next = dbu_pkg::BEAR_W'(dbu_pkg::DEG_180 + angle);
                end
                valid_next = 1'b1;
                step_next  = '0;
                state_next = dbu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dbu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dbu_pkg::ST_IDLE;
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        n_reg    <= n_next;
        prev_reg <= prev_next;
        dist_reg <= dist_next;
        bear_reg <= bear_next;
    end

    assign busy     = (state_reg != dbu_pkg::ST_IDLE);
    assign valid    = valid_reg;
    assign distance = dist_reg;
    assign bearing  = bear_reg;

endmodule

// File: design/dbu_checker.sv
// Port-level checker for the distance and bearing unit, bound to the top level.
module dbu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       mode,
    input logic       valid,
    input logic [8:0] bearing
);

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> bearing < 9'd360) else $error("bearing out of range");

    a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy)) else $error("result without a request in flight");

    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !busy) else $error("busy while showing a result");

    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode) |=> !busy) else $error("table write held the unit");

endmodule

bind distance_bearing_unit_top dbu_checker u_dbu_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
    .valid(valid), .bearing(bearing)
);

// File: sim/tb_top.sv
// Self-checking testbench for the distance and bearing unit with a queue-fed driver.
module tb_top;
    import dbu_pkg::*;

    typedef struct {
        logic                      mode;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic [8:0]                idx;
        logic [6:0]                val;
    } request_t;

    typedef struct {
        logic [DIST_W-1:0] span;
        logic [BEAR_W-1:0] bear;
    } fix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic mode = 1'b0;
    logic signed [COORD_W-1:0] observer_x = '0;
    logic signed [COORD_W-1:0] observer_y = '0;
    logic signed [COORD_W-1:0] target_x = '0;
    logic signed [COORD_W-1:0] target_y = '0;
    logic [8:0] entry_index = '0;
    logic [6:0] entry_value = '0;
    logic busy;
    logic valid;
    logic [DIST_W-1:0] distance;
    logic [BEAR_W-1:0] bearing;

    request_t pending_requests[$];
    fix_t     expected_fixes[$];
    logic [ANGLE_W-1:0] angle_table [TABLE_DEPTH];
    int accepted_count = 0;
    int errors = 0;

    distance_bearing_unit_top dut (.*);

    always #4 clk = ~clk;

    // Newton root with the same step limit and convergence exit as the block, plus zero guards.
    function automatic int unsigned newton_distance(int unsigned n);
        int unsigned prev;
        int unsigned nxt;
        bit stop;
        prev = n >> 1;
        nxt  = prev;
        stop = 1'b0;
        if (prev == 0)
            return 1;
        for (int k = 0; k < NEWTON_STEPS && !stop; k++)
        begin
            nxt = (prev + n / prev + 1) >> 1;
            if (nxt == prev || nxt == 0)
                stop = 1'b1;
            else
                prev = nxt;
        end
        return nxt;
    endfunction

    function automatic bit predict_fix(request_t r, output fix_t f);
        int dx;
        int dy;
        int unsigned adx;
        int unsigned ady;
        int unsigned span;
        int unsigned ratio;
        int a;
        int bear;
        if (r.mode)
        begin
            if (r.idx < TABLE_DEPTH)
                angle_table[r.idx] = r.val;
            return 1'b0;
        end
        dx  = int'(r.tx) - int'(r.ox);
        dy  = int'(r.oy) - int'(r.ty);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (dx == 0)
        begin
            span = ady;
            bear = dy > 0 ? 90 : 270;
        end
        else if (dy == 0)
        begin
            span = adx;
            bear = dx > 0 ? 0 : 180;
        end
        else
        begin
            span = newton_distance(adx * adx + ady * ady);
            if (span == 0)
                span = 1;
            ratio = (ady << 8) / span;
            if (ratio > 256)
                ratio = 256;
            a = angle_table[ratio];
            if (dx > 0 && dy > 0)
                bear = a;
            else if (dx > 0)
                bear = (a == 0) ? 0 : 360 - a;
            else if (dy > 0)
                bear = 180 - a;
            else
                bear = 180 + a;
        end
        if (span > 32'hFFFF)
            span = 32'hFFFF;
        f.span = span[DIST_W-1:0];
        f.bear = bear[BEAR_W-1:0];
        return 1'b1;
    endfunction

    function automatic request_t locate(int ox, int oy, int tx, int ty);
        request_t r;
        r.mode = 1'b0;
        r.ox = ox[COORD_W-1:0];
        r.oy = oy[COORD_W-1:0];
        r.tx = tx[COORD_W-1:0];
        r.ty = ty[COORD_W-1:0];
        r.idx = 9'($urandom_range(0, 511));
        r.val = 7'($urandom_range(0, 127));
        return r;
    endfunction

    function automatic request_t table_write(int i, int v);
        request_t r;
        r = locate($urandom, $urandom, $urandom, $urandom);
        r.mode = 1'b1;
        r.idx = i[8:0];
        r.val = v[6:0];
        return r;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0: return -16384;
            1: return 16383;
            default: return int'($urandom_range(0, 32767)) - 16384;
        endcase
    endfunction

    function automatic int near_coord(int c);
        int v;
        v = c + int'($urandom_range(0, 200)) - 100;
        if (v > 16383)
            v = 16383;
        if (v < -16384)
            v = -16384;
        return v;
    endfunction

    // Driver: holds a request until it is taken, then predicts its result.
    always @(posedge clk or negedge rst_n)
    begin
        fix_t f;
        bit   idle;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (predict_fix('{mode, observer_x, observer_y, target_x, target_y,
                                  entry_index, entry_value}, f))
                    expected_fixes.push_back(f);
                accepted_count++;
            end
            if (!start || !busy)
            begin
                idle = ($urandom_range(0, 99) < 20)
                       && !(accepted_count >= 500 && accepted_count < 700);
                // Once in the run, hold new requests until all results are back.
                if (accepted_count == 600 && expected_fixes.size() != 0)
                    idle = 1'b1;
                if (pending_requests.size() != 0 && !idle)
                begin
                    request_t r;
                    r = pending_requests.pop_front();
                    start       <= 1'b1;
                    mode        <= r.mode;
                    observer_x  <= r.ox;
                    observer_y  <= r.oy;
                    target_x    <= r.tx;
                    target_y    <= r.ty;
                    entry_index <= r.idx;
                    entry_value <= r.val;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest prediction.
    always @(posedge clk)
    begin
        fix_t f;
        if (rst_n && valid)
        begin
            if (expected_fixes.size() == 0)
            begin
                $error("unexpected result distance=%0d bearing=%0d", distance, bearing);
                errors++;
            end
            else
            begin
                f = expected_fixes.pop_front();
                if (distance !== f.span)
                begin
                    $error("distance expected %0d actual %0d", f.span, distance);
                    errors++;
                end
                if (bearing !== f.bear)
                begin
                    $error("bearing expected %0d actual %0d", f.bear, bearing);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int ox;
        int oy;
        // Fill the whole table first so no lookup ever hits an unwritten entry.
        pending_requests.push_back(table_write(0, 0));
        for (int i = 1; i < 256; i++)
            pending_requests.push_back(table_write(i, $urandom_range(0, 90)));
        pending_requests.push_back(table_write(256, 90));
        // Directed requests.
        pending_requests.push_back(locate(5, 5, 5, 5));
        pending_requests.push_back(locate(-16384, -16384, -16384, -16384));
        pending_requests.push_back(locate(0, 10, 0, -20));
        pending_requests.push_back(locate(0, -16384, 0, 16383));
        pending_requests.push_back(locate(-16384, 0, 16383, 0));
        pending_requests.push_back(locate(16383, 7, -16384, 7));
        pending_requests.push_back(locate(-16384, 16383, 16383, -16384));
        pending_requests.push_back(locate(16383, -16384, -16384, 16383));
        pending_requests.push_back(locate(0, 0, 3, -4));
        pending_requests.push_back(locate(0, 0, 3, 4));
        pending_requests.push_back(locate(0, 0, -3, -4));
        pending_requests.push_back(locate(0, 0, -3, 4));
        pending_requests.push_back(locate(0, 0, 1, -1));
        pending_requests.push_back(locate(0, 0, 1, -16384));
        pending_requests.push_back(locate(0, 0, 1, 1));
        pending_requests.push_back(table_write(0, 127));
        pending_requests.push_back(locate(0, 0, 100, 0));
        pending_requests.push_back(locate(0, 0, 5000, 1));
        pending_requests.push_back(table_write(0, 0));
        pending_requests.push_back(locate(0, 0, 5000, 1));
        pending_requests.push_back(table_write(300, 55));
        pending_requests.push_back(table_write(511, 127));
        pending_requests.push_back(locate(0, 0, 2, -1));
        // Random requests.
        for (int n = 0; n < 520; n++)
        begin
            ox = rand_coord();
            oy = rand_coord();
            case ($urandom_range(0, 19))
                0, 1: pending_requests.push_back(
                          table_write($urandom_range(0, 511), $urandom_range(0, 90)));
                2: pending_requests.push_back(locate(ox, oy, ox, rand_coord()));
                3: pending_requests.push_back(locate(ox, oy, rand_coord(), oy));
                4, 5, 6: pending_requests.push_back(
                          locate(ox, oy, near_coord(ox), near_coord(oy)));
                default: pending_requests.push_back(
                          locate(ox, oy, rand_coord(), rand_coord()));
            endcase
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_requests.size() == 0);
        @(posedge clk);
        while (start || busy || expected_fixes.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (errors == 0 && expected_fixes.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("tb_top failed");
        $finish;
    end
endmodule

// File: files.f
design/dbu_pkg.sv
design/dbu_ram.sv
design/dbu_div.sv
design/distance_bearing_unit_top.sv
design/dbu_checker.sv
sim/tb_top.sv
